// ----- design/ssfd_pkg.sv -----
// Shared constants, types and segment tables for the seven-segment serial frame driver.
package ssfd_pkg;

  localparam int unsigned FRAME_BITS      = 32;
  localparam int unsigned BIT_IDX_W       = $clog2(FRAME_BITS);
  localparam int unsigned QUEUE_DEPTH_DEF = 2;
  localparam int unsigned VALUE_W         = 16;
  localparam int unsigned LEVEL_W         = 4;
  localparam int unsigned DIGIT_W         = 4;
  localparam int unsigned HALF_W          = 16;
  localparam int unsigned RECIP_SHIFT     = 19;
  localparam logic [15:0] RECIP10         = 16'hCCCD;

  typedef logic [FRAME_BITS-1:0] frame_t;
  typedef logic [DIGIT_W-1:0]    digit_t;
  typedef logic [HALF_W-1:0]     half_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic half_t seg_outer(input digit_t d);
    half_t p;
    unique case (d)
      4'd0:    p = 16'h7007;
      4'd1:    p = 16'h4001;
      4'd2:    p = 16'h300B;
      4'd3:    p = 16'h600B;
      4'd4:    p = 16'h400D;
      4'd5:    p = 16'h600E;
      4'd6:    p = 16'h700E;
      4'd7:    p = 16'h4003;
      4'd8:    p = 16'h700F;
      4'd9:    p = 16'h600F;
      default: p = 16'h0000;
    endcase
    return p;
  endfunction

  function automatic half_t seg_middle(input digit_t d);
    half_t p;
    unique case (d)
      4'd0:    p = 16'h0770;
      4'd1:    p = 16'h0410;
      4'd2:    p = 16'h03B0;
      4'd3:    p = 16'h06B0;
      4'd4:    p = 16'h04D0;
      4'd5:    p = 16'h06E0;
      4'd6:    p = 16'h07E0;
      4'd7:    p = 16'h0430;
      4'd8:    p = 16'h07F0;
      4'd9:    p = 16'h06F0;
      default: p = 16'h0000;
    endcase
    return p;
  endfunction

  // levels above seven clamp to the full bar
  function automatic half_t bar_steps(input logic [LEVEL_W-1:0] lvl);
    half_t p;
    unique case (lvl)
      4'd0:    p = 16'h0000;
      4'd1:    p = 16'h0100;
      4'd2:    p = 16'h0300;
      4'd3:    p = 16'h0700;
      4'd4:    p = 16'h0F00;
      4'd5:    p = 16'h0F80;
      4'd6:    p = 16'h0FC0;
      4'd7:    p = 16'h0FE0;
      default: p = 16'h0FF0;
    endcase
    return p;
  endfunction

endpackage

// ----- design/ssfd_front.sv -----
// Front end: accepts items, splits the value into decimal digits, builds the frame.
module ssfd_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ssfd_pkg::VALUE_W-1:0]  in_display_value,
  input  logic [ssfd_pkg::LEVEL_W-1:0]  in_bar_level,
  output logic                          frm_valid,
  input  logic                          frm_ready,
  output ssfd_pkg::frame_t              frm_data
);

  logic adv;

  logic                         s1_v_r, s2_v_r, s3_v_r;
  logic [15:0]                  s1_val_r;
  logic [ssfd_pkg::LEVEL_W-1:0] s1_lvl_r, s2_lvl_r, s3_lvl_r;
  logic [31:0]                  s1_prod_r;
  logic [12:0]                  s2_q10_r;
  ssfd_pkg::digit_t             s2_ones_r, s3_ones_r, s3_tens_r;
  logic [28:0]                  s2_prod_r;
  logic [9:0]                   s3_q100_r;
  logic [25:0]                  s3_prod_r;

  logic [12:0]      q10;
  logic [15:0]      q10x10;
  logic [15:0]      ones_w;
  logic [9:0]       q100;
  logic [12:0]      q100x10;
  logic [12:0]      tens_w;
  logic [6:0]       q1000;
  logic [9:0]       q1000x10;
  logic [9:0]       hund_w;
  ssfd_pkg::digit_t hund;

  assign adv       = !s3_v_r || frm_ready;
  assign in_ready  = adv;
  assign frm_valid = s3_v_r;

  // x / 10 == (x * 0xCCCD) >> 19 for all 16-bit x
  assign q10    = s1_prod_r[31:ssfd_pkg::RECIP_SHIFT];
  assign q10x10 = ({3'b0, q10} << 3) + ({3'b0, q10} << 1);
  assign ones_w = s1_val_r - q10x10;

  assign q100    = s2_prod_r[28:ssfd_pkg::RECIP_SHIFT];
  assign q100x10 = ({3'b0, q100} << 3) + ({3'b0, q100} << 1);
  assign tens_w  = s2_q10_r - q100x10;

  assign q1000    = s3_prod_r[25:ssfd_pkg::RECIP_SHIFT];
  assign q1000x10 = ({3'b0, q1000} << 3) + ({3'b0, q1000} << 1);
  assign hund_w   = s3_q100_r - q1000x10;
  assign hund     = hund_w[3:0];

  assign frm_data = {ssfd_pkg::seg_outer(hund) | ssfd_pkg::bar_steps(s3_lvl_r),
                     ssfd_pkg::seg_middle(s3_tens_r) | ssfd_pkg::seg_outer(s3_ones_r)};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_val_r  <= in_display_value;
      s1_lvl_r  <= in_bar_level;
      s1_prod_r <= {16'b0, in_display_value} * {16'b0, ssfd_pkg::RECIP10};

      s2_lvl_r  <= s1_lvl_r;
      s2_q10_r  <= q10;
      s2_ones_r <= ones_w[3:0];
      s2_prod_r <= {16'b0, q10} * {13'b0, ssfd_pkg::RECIP10};

      s3_lvl_r  <= s2_lvl_r;
      s3_ones_r <= s2_ones_r;
      s3_tens_r <= tens_w[3:0];
      s3_q100_r <= q100;
      s3_prod_r <= {16'b0, q100} * {10'b0, ssfd_pkg::RECIP10};
    end
  end

endmodule

// ----- design/ssfd_queue.sv -----
// Short frame queue between the front end and the serializer.
module ssfd_queue #(
  parameter int unsigned DEPTH = ssfd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push_valid,
  output logic                  push_ready,
  input  ssfd_pkg::frame_t      push_data,
  output logic                  pop_valid,
  input  logic                  pop_ready,
  output ssfd_pkg::frame_t      pop_data,
  output ssfd_pkg::q_status_t   status
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  ssfd_pkg::frame_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             push, pop;

  assign status.full  = (count_r == CNT_W'(DEPTH));
  assign status.empty = (count_r == '0);
  assign push_ready   = !status.full;
  assign pop_valid    = !status.empty;
  assign pop_data     = mem_r[rd_ptr_r];
  assign push         = push_valid && push_ready;
  assign pop          = pop_valid && pop_ready;

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wrap_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= wrap_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- design/ssfd_back.sv -----
// Back end: shifts each frame out LSB first, one beat per bit, latch mark on the last.
module ssfd_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  output logic             q_ready,
  input  ssfd_pkg::frame_t q_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_serial_bit,
  output logic             out_latch_after
);

  logic                           busy_r;
  logic [ssfd_pkg::BIT_IDX_W-1:0] cnt_r;
  ssfd_pkg::frame_t               sh_r;
  logic                           take, last, load;

  assign last            = (cnt_r == ssfd_pkg::BIT_IDX_W'(ssfd_pkg::FRAME_BITS - 1));
  assign take            = busy_r && out_ready;
  assign load            = !busy_r || (take && last);
  assign q_ready         = load;
  assign out_valid       = busy_r;
  assign out_serial_bit  = sh_r[0];
  assign out_latch_after = last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (load) begin
      busy_r <= q_valid;
      cnt_r  <= '0;
    end else if (take) begin
      cnt_r  <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sh_r <= q_data;
    end else if (take) begin
      sh_r <= sh_r >> 1;
    end
  end

endmodule

// ----- design/seven_segment_serial_frame_driver.sv -----
// Top level of the seven-segment serial frame driver.
//
//   channel | direction | handshake            | beat payload
//   in_     | input     | in_valid / in_ready   | display_value[15:0], bar_level[3:0]
//   out_    | output    | out_valid / out_ready | serial_bit, latch_after
//
// Each item gives 32 output beats, LSB first; latch_after is high on the last one.
// Sustained rate is set by the one-bit-per-beat shifter, which loads the next frame as the last beat is taken.
// Item passes the 3 digit-split stages, the frame queue and the shifter register before its first beat appears.
// Front end keeps accepting while the shifter works until the frame queue fills.
// rst_n is synchronous, active low, and clears all valid and count state.
module seven_segment_serial_frame_driver #(
  parameter int unsigned QUEUE_DEPTH = ssfd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [ssfd_pkg::VALUE_W-1:0] in_display_value,
  input  logic [ssfd_pkg::LEVEL_W-1:0] in_bar_level,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_serial_bit,
  output logic                         out_latch_after
);

  logic                frm_valid, frm_ready;
  ssfd_pkg::frame_t    frm_data;
  logic                q_valid, q_ready;
  ssfd_pkg::frame_t    q_data;
  ssfd_pkg::q_status_t q_status;

  ssfd_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_display_value (in_display_value),
    .in_bar_level     (in_bar_level),
    .frm_valid        (frm_valid),
    .frm_ready        (frm_ready),
    .frm_data         (frm_data)
  );

  ssfd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (frm_valid),
    .push_ready (frm_ready),
    .push_data  (frm_data),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data),
    .status     (q_status)
  );

  ssfd_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_ready         (q_ready),
    .q_data          (q_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_serial_bit  (out_serial_bit),
    .out_latch_after (out_latch_after)
  );

  a_latch_not_twice: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_latch_after |=> !out_latch_after)
    else $error("latch mark on two consecutive beats");

  a_frame_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_latch_after |=> out_valid)
    else $error("frame ended before its last bit");

  a_queue_status: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_status.full && q_status.empty))
    else $error("queue full and empty at once");

  a_stall_from_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> q_status.full)
    else $error("input stalled while queue has room");

endmodule
